// File: rtl/core/mtl_pkg.sv
// ----------------------------------------------------------------------------
// mtl_pkg
// Shared types and constants of the markup token lexer: token codes, the
// keyword spellings and the result word that travels to the output queue.
// ----------------------------------------------------------------------------
package mtl_pkg;

    // Token type codes
    localparam logic [4:0] TOK_IDENT    = 5'd0;
    localparam logic [4:0] TOK_ASSET    = 5'd1;
    localparam logic [4:0] TOK_NUMBER   = 5'd4;
    localparam logic [4:0] TOK_STRING   = 5'd5;
    localparam logic [4:0] TOK_COMMENT  = 5'd6;
    localparam logic [4:0] TOK_GARBAGE  = 5'd7;
    localparam logic [4:0] TOK_AT       = 5'd8;
    localparam logic [4:0] TOK_COLON    = 5'd9;
    localparam logic [4:0] TOK_COMMA    = 5'd10;
    localparam logic [4:0] TOK_LBRACE   = 5'd11;
    localparam logic [4:0] TOK_RBRACE   = 5'd12;
    localparam logic [4:0] TOK_DOTDOT   = 5'd13;
    localparam logic [4:0] TOK_HASH     = 5'd14;
    localparam logic [4:0] TOK_LPAREN   = 5'd15;
    localparam logic [4:0] TOK_RPAREN   = 5'd16;
    localparam logic [4:0] TOK_PERCENT  = 5'd17;
    localparam logic [4:0] TOK_NEWLINE  = 5'd18;

    // Keyword table: asset, define, external
    localparam int unsigned NUM_KW = 3;

    function automatic logic [3:0] kw_len(input logic [1:0] k);
        logic [3:0] v;
        case (k)
            2'd0:    v = 4'd5;
            2'd1:    v = 4'd6;
            2'd2:    v = 4'd8;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] v;
        v = 8'h00;
        case (k)
            2'd0: begin
                case (idx)
                    3'd0:    v = "a";
                    3'd1:    v = "s";
                    3'd2:    v = "s";
                    3'd3:    v = "e";
                    3'd4:    v = "t";
                    default: v = 8'h00;
                endcase
            end
            2'd1: begin
                case (idx)
                    3'd0:    v = "d";
                    3'd1:    v = "e";
                    3'd2:    v = "f";
                    3'd3:    v = "i";
                    3'd4:    v = "n";
                    3'd5:    v = "e";
                    default: v = 8'h00;
                endcase
            end
            2'd2: begin
                case (idx)
                    3'd0:    v = "e";
                    3'd1:    v = "x";
                    3'd2:    v = "t";
                    3'd3:    v = "e";
                    3'd4:    v = "r";
                    3'd5:    v = "n";
                    3'd6:    v = "a";
                    3'd7:    v = "l";
                    default: v = 8'h00;
                endcase
            end
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // One result word
    typedef struct packed {
        logic [4:0]  typ;
        logic [31:0] start;
        logic [15:0] len;
        logic [7:0]  first;
        logic        last;
    } t_token;

    // Up to two results from one source byte
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_lex_res;

endpackage

// File: rtl/core/markup_token_lexer.sv
// ----------------------------------------------------------------------------
// markup_token_lexer
// Streaming tokenizer: one source byte (or end marker) per word in, token
// spans out (type, start offset, length, first byte, last-of-run flag).
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  input   | in        | i_valid / o_stall  | i_char_byte, i_end_of_input
//  output  | out       | o_valid / i_stall  | o_token_type, o_start_offset,
//          |           |                    | o_span_length, o_first_byte,
//          |           |                    | o_last_of_run
//
//  One byte per cycle while neither side stalls: a byte is held in the input
//  register, then the lexer state steps and writes its tokens to a
//  four-entry queue, from whose head the output word is read.
//  A byte that yields two tokens is handed out as two output words, so the
//  input holds off when the queue has fewer than two free entries.
//  Synchronous active-low reset returns the lexer to leading-whitespace mode
//  with offset zero and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module markup_token_lexer #(
    parameter int OFFSET_WIDTH = 32,
    parameter int LENGTH_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_token_type,
    output logic [31:0] o_start_offset,
    output logic [15:0] o_span_length,
    output logic [7:0]  o_first_byte,
    output logic        o_last_of_run
);
    import mtl_pkg::*;

    logic       r_in_v;
    logic [7:0] r_byte;
    logic       r_eoi;
    logic       room;
    logic       take;
    t_lex_res   res;
    t_token     tok;

    assign take    = r_in_v && room;
    assign o_stall = r_in_v && !room;

    // Input register: load whenever the held word moves on or is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (!o_stall) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_char_byte;
            r_eoi  <= i_end_of_input;
        end
    end

    mtl_lex_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_byte),
        .i_eoi   (r_eoi),
        .o_res   (res)
    );

    mtl_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_tok   (tok)
    );

    assign o_token_type   = tok.typ;
    assign o_start_offset = tok.start;
    assign o_span_length  = tok.len;
    assign o_first_byte   = tok.first;
    assign o_last_of_run  = tok.last;

endmodule

// File: rtl/core/mtl_lex_core.sv
// ----------------------------------------------------------------------------
// mtl_lex_core
// Lexer state and next-state logic. Takes one byte or end marker per cycle
// when i_take is high and reports the zero, one or two tokens it causes.
// ----------------------------------------------------------------------------
module mtl_lex_core #(
    parameter int OFFSET_WIDTH = 32,
    parameter int LENGTH_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_eoi,
    output mtl_pkg::t_lex_res o_res
);
    import mtl_pkg::*;

    // Lexer modes
    localparam logic [3:0] M_LEAD    = 4'd0;
    localparam logic [3:0] M_IDLE    = 4'd1;
    localparam logic [3:0] M_IDENT   = 4'd2;
    localparam logic [3:0] M_NUM     = 4'd3;
    localparam logic [3:0] M_STRQ    = 4'd4;
    localparam logic [3:0] M_STRA    = 4'd5;
    localparam logic [3:0] M_SLASH   = 4'd6;
    localparam logic [3:0] M_COMMENT = 4'd7;
    localparam logic [3:0] M_DOT     = 4'd8;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    logic [3:0]              r_mode,  n_mode;
    logic [OFFSET_WIDTH-1:0] r_off,   n_off;
    logic [OFFSET_WIDTH-1:0] r_start, n_start;
    logic [LENGTH_WIDTH-1:0] r_len,   n_len;
    logic [2:0]              r_cand,  n_cand;
    logic [7:0]              r_first, n_first;

    function automatic logic is_alpha_us(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [31:0] off32(input logic [OFFSET_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    function automatic logic [15:0] len16(input logic [LENGTH_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic t_token mk_tok(input logic [4:0] typ, input logic [31:0] start,
                                      input logic [15:0] len, input logic [7:0] first);
        t_token t;
        t.typ   = typ;
        t.start = start;
        t.len   = len;
        t.first = first;
        t.last  = 1'b0;
        return t;
    endfunction

    // Saturating length and keyword tracking for the current byte
    logic [LENGTH_WIDTH-1:0] len_inc;
    logic [2:0]              cand_trk;
    logic [2:0]              cand_first;
    logic [4:0]              ident_typ;

    always_comb begin
        len_inc = (r_len == LEN_MAX) ? r_len : r_len + LENGTH_WIDTH'(1);
        for (int k = 0; k < NUM_KW; k++) begin
            cand_trk[k] = r_cand[k]
                && (r_len < LENGTH_WIDTH'(kw_len(2'(k))))
                && (kw_char(2'(k), r_len[2:0]) == i_byte);
            cand_first[k] = (kw_char(2'(k), 3'd0) == i_byte);
        end
        ident_typ = TOK_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (r_cand[k] && r_len == LENGTH_WIDTH'(kw_len(2'(k)))) begin
                ident_typ = TOK_ASSET + 5'(k);
            end
        end
    end

    // Byte seen between tokens: skip a blank, start a token or emit a single token
    logic [3:0]              ib_mode;
    logic                    ib_load;
    logic [LENGTH_WIDTH-1:0] ib_len;
    logic [7:0]              ib_first;
    logic [2:0]              ib_cand;
    logic                    ib_v;
    logic [4:0]              ib_typ;
    t_token                  ib_tok;

    always_comb begin
        ib_mode  = M_IDLE;
        ib_load  = 1'b0;
        ib_len   = LENGTH_WIDTH'(1);
        ib_first = i_byte;
        ib_cand  = 3'b111;
        ib_v     = 1'b0;
        ib_typ   = TOK_GARBAGE;
        if (is_space(i_byte) && i_byte != 8'h0A) begin
            ib_mode = M_IDLE;
        end else if (is_alpha_us(i_byte)) begin
            ib_mode = M_IDENT;
            ib_load = 1'b1;
            ib_cand = cand_first;
        end else if (is_digit(i_byte)) begin
            ib_mode = M_NUM;
            ib_load = 1'b1;
        end else begin
            case (i_byte)
                "\"": begin
                    ib_mode = M_STRQ; ib_load = 1'b1; ib_len = '0; ib_first = 8'h00;
                end
                "<": begin
                    ib_mode = M_STRA; ib_load = 1'b1; ib_len = '0; ib_first = 8'h00;
                end
                "/":     begin ib_mode = M_SLASH; ib_load = 1'b1; end
                ".":     begin ib_mode = M_DOT;   ib_load = 1'b1; end
                8'h0A:   begin ib_v = 1'b1; ib_typ = TOK_NEWLINE; end
                "@":     begin ib_v = 1'b1; ib_typ = TOK_AT;      end
                ":":     begin ib_v = 1'b1; ib_typ = TOK_COLON;   end
                ",":     begin ib_v = 1'b1; ib_typ = TOK_COMMA;   end
                "{":     begin ib_v = 1'b1; ib_typ = TOK_LBRACE;  end
                "}":     begin ib_v = 1'b1; ib_typ = TOK_RBRACE;  end
                "#":     begin ib_v = 1'b1; ib_typ = TOK_HASH;    end
                "(":     begin ib_v = 1'b1; ib_typ = TOK_LPAREN;  end
                ")":     begin ib_v = 1'b1; ib_typ = TOK_RPAREN;  end
                "%":     begin ib_v = 1'b1; ib_typ = TOK_PERCENT; end
                default: begin ib_v = 1'b1; ib_typ = TOK_GARBAGE; end
            endcase
        end
        if (ib_typ == TOK_NEWLINE) begin
            ib_tok = mk_tok(TOK_NEWLINE, off32(r_off), 16'd2, "\\");
        end else begin
            ib_tok = mk_tok(ib_typ, off32(r_off), 16'd1, i_byte);
        end
    end

    // Mode step: pending token, then the byte's own effect
    logic   pre_v;
    t_token pre_tok;
    logic   use_ib;
    logic   ib_emit;
    t_token cur_tok;

    always_comb begin
        n_mode  = r_mode;
        n_off   = r_off;
        n_start = r_start;
        n_len   = r_len;
        n_cand  = r_cand;
        n_first = r_first;
        pre_v   = 1'b0;
        use_ib  = 1'b0;
        cur_tok = mk_tok(ident_typ, off32(r_start), len16(r_len), r_first);
        case (r_mode)
            M_NUM:           cur_tok.typ = TOK_NUMBER;
            M_STRQ, M_STRA:  cur_tok.typ = TOK_STRING;
            M_COMMENT:       cur_tok = mk_tok(TOK_COMMENT, off32(r_start), 16'd7, "c");
            M_SLASH:         cur_tok = mk_tok(TOK_GARBAGE, off32(r_start), 16'd1, "/");
            M_DOT:           cur_tok = mk_tok(TOK_GARBAGE, off32(r_start), 16'd1, ".");
            default:         cur_tok.typ = ident_typ;
        endcase
        pre_tok = cur_tok;

        if (i_eoi) begin
            // flush what is pending, then return to reset state
            case (r_mode)
                M_IDENT, M_NUM, M_STRQ, M_STRA, M_COMMENT, M_SLASH, M_DOT: pre_v = 1'b1;
                default: pre_v = 1'b0;
            endcase
            n_mode  = M_LEAD;
            n_off   = '0;
            n_start = '0;
            n_len   = '0;
            n_cand  = 3'b111;
            n_first = 8'h00;
        end else begin
            n_off = r_off + OFFSET_WIDTH'(1);
            case (r_mode)
                M_LEAD: begin
                    use_ib = !is_space(i_byte);
                end
                M_IDENT: begin
                    if (is_alpha_us(i_byte)) begin
                        n_cand = cand_trk;
                        n_len  = len_inc;
                    end else begin
                        pre_v  = 1'b1;
                        use_ib = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(i_byte)) begin
                        n_len = len_inc;
                    end else begin
                        pre_v  = 1'b1;
                        use_ib = 1'b1;
                    end
                end
                M_STRQ, M_STRA: begin
                    if ((r_mode == M_STRQ && i_byte == "\"")
                            || (r_mode == M_STRA && i_byte == ">")) begin
                        pre_v  = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        if (r_len == '0) begin
                            n_first = i_byte;
                        end
                        n_len = len_inc;
                    end
                end
                M_SLASH: begin
                    if (i_byte == "/") begin
                        n_mode = M_COMMENT;
                    end else begin
                        pre_v  = 1'b1;
                        use_ib = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_byte == 8'h0A) begin
                        pre_v  = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_DOT: begin
                    if (i_byte == ".") begin
                        pre_v   = 1'b1;
                        pre_tok = mk_tok(TOK_DOTDOT, off32(r_start), 16'd2, ".");
                        n_mode  = M_IDLE;
                    end else begin
                        pre_v  = 1'b1;
                        use_ib = 1'b1;
                    end
                end
                default: begin
                    use_ib = 1'b1;
                end
            endcase
            if (use_ib) begin
                n_mode = ib_mode;
                if (ib_load) begin
                    n_start = r_off;
                    n_len   = ib_len;
                    n_first = ib_first;
                    n_cand  = ib_cand;
                end
            end
        end
        ib_emit = use_ib && ib_v;
    end

    // Pack the results in order and mark the final one
    always_comb begin
        o_res.cnt  = {1'b0, pre_v} + {1'b0, ib_emit};
        o_res.tok0 = pre_v ? pre_tok : ib_tok;
        o_res.tok1 = ib_tok;
        o_res.tok0.last = !(pre_v && ib_emit);
        o_res.tok1.last = 1'b1;
        if (!i_take) begin
            o_res.cnt = 2'd0;
        end
    end

    // Advance state on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_LEAD;
            r_off   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_cand  <= 3'b111;
            r_first <= 8'h00;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_off   <= n_off;
            r_start <= n_start;
            r_len   <= n_len;
            r_cand  <= n_cand;
            r_first <= n_first;
        end
    end

endmodule

// File: rtl/core/mtl_out_queue.sv
// ----------------------------------------------------------------------------
// mtl_out_queue
// Four-entry result queue. Takes up to two tokens per cycle from the lexer
// and hands out one word per cycle on the output channel unless it stalls.
// ----------------------------------------------------------------------------
module mtl_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtl_pkg::t_lex_res i_res,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output mtl_pkg::t_token   o_tok
);
    import mtl_pkg::*;

    t_token     r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       pop;

    // Room for two more words regardless of the output side
    assign o_room  = r_cnt <= 3'd2;
    assign o_valid = r_cnt != 3'd0;
    assign o_tok   = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;

    // Write the payload words
    always_ff @(posedge i_clk) begin
        if (i_res.cnt != 2'd0) begin
            r_mem[r_wr] <= i_res.tok0;
        end
        if (i_res.cnt == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_res.tok1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + i_res.cnt;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_res.cnt} - {2'b00, pop};
        end
    end

endmodule

// File: tb/markup_token_checker.sv
// ----------------------------------------------------------------------------
// markup_token_checker
// Watches both channels of the markup token lexer. Every accepted source
// word is run through a local tokenizer that predicts the token spans it
// causes, and every accepted token word is compared field by field against
// the oldest prediction. The failure and pending counts go to the top.
// ----------------------------------------------------------------------------
module markup_token_checker
    import mtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_input,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [4:0]  i_token_type,
    input  logic [31:0] i_start_offset,
    input  logic [15:0] i_span_length,
    input  logic [7:0]  i_first_byte,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Tokenizer modes
    localparam logic [3:0] LX_LEAD    = 4'd0;
    localparam logic [3:0] LX_IDLE    = 4'd1;
    localparam logic [3:0] LX_IDENT   = 4'd2;
    localparam logic [3:0] LX_NUM     = 4'd3;
    localparam logic [3:0] LX_STRQ    = 4'd4;
    localparam logic [3:0] LX_STRA    = 4'd5;
    localparam logic [3:0] LX_SLASH   = 4'd6;
    localparam logic [3:0] LX_COMMENT = 4'd7;
    localparam logic [3:0] LX_DOT     = 4'd8;

    localparam logic [15:0] SPAN_MAX = 16'hFFFF;

    string       kw_word [3] = '{"asset", "define", "external"};

    // Tokenizer state
    logic [3:0]  mode;
    logic [31:0] offset;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [2:0]  kw_alive;
    logic [7:0]  tok_first;

    t_token      step_toks [$];
    t_token      span_queue [$];
    int          n_fail = 0;
    int          n_pending = 0;

    assign o_fail_count = n_fail;
    assign o_pending    = n_pending;

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic bit is_digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic clear_lexer();
        mode      = LX_LEAD;
        offset    = '0;
        tok_start = '0;
        tok_len   = '0;
        kw_alive  = 3'b111;
        tok_first = '0;
    endtask

    task automatic add_span(input logic [4:0] typ, input logic [31:0] start,
                            input logic [15:0] len, input logic [7:0] first);
        t_token t;
        t.typ   = typ;
        t.start = start;
        t.len   = len;
        t.first = first;
        t.last  = 1'b0;
        step_toks = {step_toks, t};
    endtask

    task automatic open_token(input logic [3:0] m, input logic [15:0] len,
                              input logic [7:0] first);
        mode      = m;
        tok_start = offset;
        tok_len   = len;
        tok_first = first;
        kw_alive  = 3'b111;
    endtask

    task automatic grow_span();
        if (tok_len != SPAN_MAX) begin
            tok_len++;
        end
    endtask

    // Drop keywords that no longer match the identifier so far
    task automatic prune_keywords(input logic [7:0] c);
        for (int k = 0; k < 3; k++) begin
            if (kw_alive[k] && (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != c)) begin
                kw_alive[k] = 1'b0;
            end
        end
    endtask

    task automatic close_ident();
        logic [4:0] typ;
        typ = TOK_IDENT;
        for (int k = 0; k < 3; k++) begin
            if (kw_alive[k] && tok_len == kw_word[k].len()) begin
                typ = TOK_ASSET + 5'(k);
            end
        end
        add_span(typ, tok_start, tok_len, tok_first);
    endtask

    // Byte seen between tokens
    task automatic lex_fresh(input logic [7:0] c);
        logic [4:0] punct;
        mode = LX_IDLE;
        if (is_blank(c) && c != "\n") begin
            return;
        end
        if (is_word_char(c)) begin
            open_token(LX_IDENT, 16'd0, c);
            prune_keywords(c);
            grow_span();
            return;
        end
        if (is_digit_char(c)) begin
            open_token(LX_NUM, 16'd1, c);
            return;
        end
        case (c)
            "\"": begin
                open_token(LX_STRQ, 16'd0, 8'd0);
                return;
            end
            "<": begin
                open_token(LX_STRA, 16'd0, 8'd0);
                return;
            end
            "/": begin
                open_token(LX_SLASH, 16'd1, "/");
                return;
            end
            ".": begin
                open_token(LX_DOT, 16'd1, ".");
                return;
            end
            "\n": begin
                add_span(TOK_NEWLINE, offset, 16'd2, "\\");
                return;
            end
            "@":     punct = TOK_AT;
            ":":     punct = TOK_COLON;
            ",":     punct = TOK_COMMA;
            "{":     punct = TOK_LBRACE;
            "}":     punct = TOK_RBRACE;
            "#":     punct = TOK_HASH;
            "(":     punct = TOK_LPAREN;
            ")":     punct = TOK_RPAREN;
            "%":     punct = TOK_PERCENT;
            default: punct = TOK_GARBAGE;
        endcase
        add_span(punct, offset, 16'd1, c);
    endtask

    // Byte seen inside a string
    task automatic lex_string(input logic [7:0] c, input logic [7:0] closer);
        if (c == closer) begin
            add_span(TOK_STRING, tok_start, tok_len, tok_first);
            mode = LX_IDLE;
        end else begin
            if (tok_len == 0) begin
                tok_first = c;
            end
            grow_span();
        end
    endtask

    // Work out the spans of one source word and queue them
    task automatic predict_spans(input logic [7:0] c, input logic eoi);
        if (eoi) begin
            case (mode)
                LX_IDENT:        close_ident();
                LX_NUM:          add_span(TOK_NUMBER, tok_start, tok_len, tok_first);
                LX_STRQ, LX_STRA: add_span(TOK_STRING, tok_start, tok_len, tok_first);
                LX_COMMENT:      add_span(TOK_COMMENT, tok_start, 16'd7, "c");
                LX_SLASH:        add_span(TOK_GARBAGE, tok_start, 16'd1, "/");
                LX_DOT:          add_span(TOK_GARBAGE, tok_start, 16'd1, ".");
                default: ;
            endcase
            clear_lexer();
        end else begin
            case (mode)
                LX_LEAD: begin
                    if (!is_blank(c)) begin
                        lex_fresh(c);
                    end
                end
                LX_IDENT: begin
                    if (is_word_char(c)) begin
                        prune_keywords(c);
                        grow_span();
                    end else begin
                        close_ident();
                        lex_fresh(c);
                    end
                end
                LX_NUM: begin
                    if (is_digit_char(c)) begin
                        grow_span();
                    end else begin
                        add_span(TOK_NUMBER, tok_start, tok_len, tok_first);
                        lex_fresh(c);
                    end
                end
                LX_STRQ: lex_string(c, "\"");
                LX_STRA: lex_string(c, ">");
                LX_SLASH: begin
                    if (c == "/") begin
                        mode = LX_COMMENT;
                    end else begin
                        add_span(TOK_GARBAGE, tok_start, 16'd1, "/");
                        lex_fresh(c);
                    end
                end
                LX_COMMENT: begin
                    if (c == "\n") begin
                        add_span(TOK_COMMENT, tok_start, 16'd7, "c");
                        mode = LX_IDLE;
                    end
                end
                LX_DOT: begin
                    if (c == ".") begin
                        add_span(TOK_DOTDOT, tok_start, 16'd2, ".");
                        mode = LX_IDLE;
                    end else begin
                        add_span(TOK_GARBAGE, tok_start, 16'd1, ".");
                        lex_fresh(c);
                    end
                end
                default: lex_fresh(c);
            endcase
            offset++;
        end
        // Flag the final span of this word, then hand all of them on
        if (step_toks.size() > 0) begin
            step_toks[step_toks.size() - 1].last = 1'b1;
        end
        span_queue = {span_queue, step_toks};
        step_toks.delete();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $error("token field %s: expected %0d, got %0d", name, want, seen);
            n_fail++;
        end
    endtask

    // Compare outgoing words first, then predict from the incoming one
    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            clear_lexer();
            span_queue.delete();
            step_toks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (span_queue.size() == 0) begin
                    $error("token word with none expected: type %0d start %0d",
                           i_token_type, i_start_offset);
                    n_fail++;
                end else begin
                    want = span_queue.pop_front();
                    check_field("token_type", 32'(want.typ), 32'(i_token_type));
                    check_field("start_offset", want.start, i_start_offset);
                    check_field("span_length", 32'(want.len), 32'(i_span_length));
                    check_field("first_byte", 32'(want.first), 32'(i_first_byte));
                    check_field("last_of_run", 32'(want.last), 32'(i_last_of_run));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_spans(i_char_byte, i_end_of_input);
            end
        end
        n_pending = span_queue.size();
    end

endmodule

// File: tb/tb_markup_token_lexer.sv
// ----------------------------------------------------------------------------
// tb_markup_token_lexer
// Feeds the markup token lexer a short hand-written source text, then random
// token sequences, noise and end markers until twelve hundred words other than blanks have gone in.
// Both sides idle at random and the output side holds off for long
// stretches so the lexer fills and stalls its input. A checker beside the
// block does the scoring.
// ----------------------------------------------------------------------------
module tb_markup_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import mtl_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_byte;
    logic        end_in;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  tok_type;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [7:0]  tok_first;
    logic        tok_last;
    int          fail_count;
    int          pending;

    string       kw_word [3] = '{"asset", "define", "external"};
    bit          gaps_on = 1'b1;
    int          fed = 0;

    always #1 clk = ~clk;

    markup_token_lexer u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_char_byte    (char_byte),
        .i_end_of_input (end_in),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_token_type   (tok_type),
        .o_start_offset (tok_start),
        .o_span_length  (tok_len),
        .o_first_byte   (tok_first),
        .o_last_of_run  (tok_last)
    );

    markup_token_checker u_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_char_byte    (char_byte),
        .i_end_of_input (end_in),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_token_type   (tok_type),
        .i_start_offset (tok_start),
        .i_span_length  (tok_len),
        .i_first_byte   (tok_first),
        .i_last_of_run  (tok_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Offer one word from a falling edge and hold it until taken
    task automatic push_word(input logic [7:0] c, input logic eoi);
        if (gaps_on && $urandom_range(99) < 15) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        in_valid  = 1'b1;
        char_byte = c;
        end_in    = eoi;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (eoi || c == "\n" || !(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
            fed++;
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_word(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(52);
        if (r == 52) begin
            return "_";
        end
        return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    // Any byte but the one given
    function automatic logic [7:0] rand_byte_not(input logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == avoid);
        return b;
    endfunction

    task automatic push_letters(input int n);
        repeat (n) push_word(rand_letter(), 1'b0);
    endtask

    task automatic push_blank();
        case ($urandom_range(5))
            0:       push_word(8'h09, 1'b0);
            1:       push_word(8'h0B, 1'b0);
            2:       push_word(8'h0C, 1'b0);
            3:       push_word(8'h0D, 1'b0);
            4:       push_word(8'h0A, 1'b0);
            default: push_word(8'h20, 1'b0);
        endcase
    endtask

    // One random piece of source text
    task automatic feed_piece();
        int    r;
        int    k;
        int    n;
        string punct;
        logic [7:0] closer;
        punct = "@:,{}#()%./\n";
        r = $urandom_range(99);
        k = $urandom_range(2);
        if (r < 12) begin
            push_text(kw_word[k]);
        end else if (r < 18) begin
            // Near miss: a cut keyword or one with a letter too many
            if ($urandom_range(1)) begin
                push_text(kw_word[k].substr(0, $urandom_range(kw_word[k].len() - 2)));
            end else begin
                push_text(kw_word[k]);
                push_word(rand_letter(), 1'b0);
            end
        end else if (r < 32) begin
            push_letters($urandom_range(1, 8));
        end else if (r < 42) begin
            repeat ($urandom_range(1, 6)) push_word(rand_digit(), 1'b0);
        end else if (r < 56) begin
            closer = (r < 50) ? "\"" : ">";
            push_word((r < 50) ? "\"" : "<", 1'b0);
            repeat ($urandom_range(0, 6)) push_word(rand_byte_not(closer), 1'b0);
            push_word(closer, 1'b0);
        end else if (r < 63) begin
            push_text("//");
            repeat ($urandom_range(0, 6)) push_word(rand_byte_not("\n"), 1'b0);
            push_word("\n", 1'b0);
        end else if (r < 78) begin
            n = $urandom_range(punct.len());
            if (n == punct.len()) begin
                push_text("..");
            end else begin
                push_word(punct[n], 1'b0);
            end
        end else if (r < 88) begin
            repeat ($urandom_range(1, 3)) push_blank();
        end else if (r < 96) begin
            push_word(8'($urandom_range(255)), 1'b0);
        end else if (r < 98) begin
            // Cut a token short with the end marker
            case ($urandom_range(6))
                0:       push_letters($urandom_range(1, 6));
                1:       push_word(rand_digit(), 1'b0);
                2:       push_text("\"ab");
                3:       push_text("<");
                4:       push_text("//x");
                5:       push_text("/");
                default: push_text(".");
            endcase
            push_word(8'($urandom_range(255)), 1'b1);
        end else begin
            push_word(8'($urandom_range(255)), 1'b1);
        end
    endtask

    // Output side: random stalls, two long hold-offs, one quiet window
    initial begin
        int unsigned cyc;
        int unsigned hold_left;
        cyc       = 0;
        hold_left = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc == 400 || cyc == 900) begin
                hold_left = 80;
            end
            if (hold_left != 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (cyc >= 1100 && cyc < 1500) begin
                out_stall = 1'b0;
            end else begin
                out_stall = ($urandom_range(99) < 15);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_byte = 8'd0;
        end_in    = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Hand-written opening: leading blanks, keyword, every string form,
        // comment, double dot, lone slash and dot, high byte, NUL
        push_text(" \n\tasset:12\"\"<a>//x\n..@/.");
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b1);

        fed = 0;
        while (fed < 1200) begin
            gaps_on = !(fed >= 500 && fed < 800);
            feed_piece();
        end
        in_valid = 1'b0;

        // Drain, then let the pipeline settle
        while (pending != 0) @(negedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: markup_token_lexer.f
rtl/core/mtl_pkg.sv
rtl/core/mtl_lex_core.sv
rtl/core/mtl_out_queue.sv
rtl/core/markup_token_lexer.sv
tb/markup_token_checker.sv
tb/tb_markup_token_lexer.sv
